[src/ebrm_pkg.sv]
// Package for the eight-bit register machine step block.
// Holds beat payload types, access kinds, opcodes and the execute-unit result type.
// No dependencies.
package ebrm_pkg;

    // Access kinds
    localparam logic [2:0] KIND_EXEC    = 3'd0;
    localparam logic [2:0] KIND_PRE_REG = 3'd1;
    localparam logic [2:0] KIND_PRE_MEM = 3'd2;
    localparam logic [2:0] KIND_RD_MEM  = 3'd3;
    localparam logic [2:0] KIND_RD_REG  = 3'd4;

    // Opcodes (top nibble of the instruction word)
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_INC   = 4'd3;
    localparam logic [3:0] OP_AND   = 4'd4;
    localparam logic [3:0] OP_OR    = 4'd5;
    localparam logic [3:0] OP_NOT   = 4'd6;
    localparam logic [3:0] OP_XOR   = 4'd7;
    localparam logic [3:0] OP_LOAD  = 4'd8;
    localparam logic [3:0] OP_STORE = 4'd9;
    localparam logic [3:0] OP_JMP   = 4'd10;
    localparam logic [3:0] OP_BEQZ  = 4'd11;
    localparam logic [3:0] OP_HLT   = 4'd15;

    // Storage geometry
    localparam int NUM_REGS  = 16;
    localparam int REG_AW    = 4;
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = 8;

    typedef struct packed {
        logic [2:0]        access_kind;
        logic [15:0]       instruction;
        logic [7:0]        target_index;
        logic signed [7:0] preload_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        next_pc;
        logic              halted;
        logic              illegal;
        logic signed [7:0] read_value;
        logic              reg_written;
        logic [3:0]        written_reg;
        logic signed [7:0] written_value;
    } t_out_item;

    // Decoded effect of one executed instruction
    typedef struct packed {
        logic [7:0] result;
        logic       wr;
        logic [7:0] next_pc;
        logic       illegal;
        logic       halt;
        logic       is_load;
        logic       is_store;
        logic [7:0] addr;
    } t_exec;

endpackage

[src/eight_bit_register_machine_step_top.sv]
// Top level of the eight-bit register machine step block.
// Instantiates ebrm_rf, ebrm_dmem and ebrm_exec; depends on ebrm_pkg.
//
// Each input beat executes one 16-bit instruction, preloads a register or data byte,
// or reads one back, and yields exactly one result beat. The block accepts one beat
// per cycle as long as results are taken and returns its result from the output
// register after execute and writeback. Register file reads are registered at
// acceptance, the execute stage computes and performs the data-memory access, and
// the writeback stage writes the register file; a write-first register file and a
// forward from writeback into execute let dependent instructions follow each other
// in consecutive cycles. Backpressure on the result side stalls the pipeline only
// once no bubble is left. Register file and data memory read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
module eight_bit_register_machine_step_top
    import ebrm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Stage control
    logic en_out;
    logic en2;
    logic en1;
    logic acc;
    logic step1;

    // Execute-stage registers
    logic     r_v1;
    t_in_item r_s1;

    // Architectural pc and halt flag
    logic [7:0] r_pc;
    logic       r_halt;

    // Writeback-stage registers
    logic        r_v2;
    logic        r2_wr;
    logic [3:0]  r2_wreg;
    logic [7:0]  r2_alu;
    logic        r2_from_mem;
    logic        r2_rd_mem;
    logic        r2_rd_reg;
    logic [7:0]  r2_regval;
    logic [7:0]  r2_pc;
    logic        r2_halted;
    logic        r2_illegal;
    logic        r2_rep;

    // Output register
    logic      r_ov;
    t_out_item r_out;
    t_out_item n_out;

    // Execute-stage signals
    logic [2:0] kind;
    logic [3:0] op;
    logic [3:0] fd;
    logic [3:0] fs1;
    logic [3:0] fs2;
    logic [3:0] c_addr;
    logic [3:0] rd_c_addr;
    logic [7:0] rf_a;
    logic [7:0] rf_b;
    logic [7:0] rf_c;
    logic [7:0] op_a;
    logic [7:0] op_b;
    logic [7:0] op_c;
    logic [7:0] s2_wval;
    logic       do_exec;
    t_exec      ex;
    logic       dm_we;
    logic       dm_rd;
    logic       dm_en;
    logic [7:0] dm_addr;
    logic [7:0] dm_wdata;
    logic [7:0] dm_rdata;
    logic       rf_we;

    // Advance each stage when the next one is free or moving
    assign en_out     = !r_ov || i_out_ready;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;
    assign acc        = i_in_valid && en1;
    assign step1      = r_v1 && en2;

    // Register file, read at acceptance
    assign rd_c_addr = (i_in_item.access_kind == KIND_EXEC) ? i_in_item.instruction[11:8]
                                                           : i_in_item.target_index[3:0];
    assign rf_we     = r_v2 && en_out && r2_wr;
    assign s2_wval   = r2_from_mem ? dm_rdata : r2_alu;

    ebrm_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (rf_we),
        .i_waddr   (r2_wreg),
        .i_wdata   (s2_wval),
        .i_re      (acc),
        .i_raddr_a (i_in_item.instruction[7:4]),
        .i_raddr_b (i_in_item.instruction[3:0]),
        .i_raddr_c (rd_c_addr),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b),
        .o_rdata_c (rf_c)
    );

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= i_in_item;
        end
    end

    // Decode fields and forward the writeback value into execute
    assign kind    = r_s1.access_kind;
    assign op      = r_s1.instruction[15:12];
    assign fd      = r_s1.instruction[11:8];
    assign fs1     = r_s1.instruction[7:4];
    assign fs2     = r_s1.instruction[3:0];
    assign c_addr  = (kind == KIND_EXEC) ? fd : r_s1.target_index[3:0];
    assign op_a    = (r_v2 && r2_wr && r2_wreg == fs1) ? s2_wval : rf_a;
    assign op_b    = (r_v2 && r2_wr && r2_wreg == fs2) ? s2_wval : rf_b;
    assign op_c    = (r_v2 && r2_wr && r2_wreg == c_addr) ? s2_wval : rf_c;
    assign do_exec = (kind == KIND_EXEC) && !r_halt;

    ebrm_exec u_exec (
        .i_op   (op),
        .i_d    (fd),
        .i_s1   (fs1),
        .i_s2   (fs2),
        .i_a    (op_a),
        .i_b    (op_b),
        .i_dv   (op_c),
        .i_pc   (r_pc),
        .o_exec (ex)
    );

    // Data memory access from execute
    assign dm_we    = (do_exec && ex.is_store) || (kind == KIND_PRE_MEM);
    assign dm_rd    = (do_exec && ex.is_load) || (kind == KIND_RD_MEM);
    assign dm_en    = step1 && (dm_we || dm_rd);
    assign dm_addr  = (kind == KIND_EXEC) ? ex.addr : r_s1.target_index;
    assign dm_wdata = (kind == KIND_EXEC) ? op_c : r_s1.preload_value;

    ebrm_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (dm_en),
        .i_we    (dm_we),
        .i_addr  (dm_addr),
        .i_wdata (dm_wdata),
        .o_rdata (dm_rdata)
    );

    // Advance pc and halt flag as an instruction leaves execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_halt <= 1'b0;
        end else if (step1 && do_exec) begin
            r_pc   <= ex.next_pc;
            r_halt <= r_halt | ex.halt;
        end
    end

    // Writeback stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step1) begin
            r2_wr       <= (do_exec && ex.wr) || (kind == KIND_PRE_REG);
            r2_wreg     <= c_addr;
            r2_alu      <= (kind == KIND_EXEC) ? ex.result : r_s1.preload_value;
            r2_from_mem <= do_exec && ex.is_load;
            r2_rd_mem   <= (kind == KIND_RD_MEM);
            r2_rd_reg   <= (kind == KIND_RD_REG);
            r2_regval   <= op_c;
            r2_pc       <= do_exec ? ex.next_pc : r_pc;
            r2_halted   <= r_halt | (do_exec & ex.halt);
            r2_illegal  <= do_exec & ex.illegal;
            r2_rep      <= do_exec & ex.wr;
        end
    end

    // Assemble the result beat
    always_comb begin
        n_out.next_pc       = r2_pc;
        n_out.halted        = r2_halted;
        n_out.illegal       = r2_illegal;
        n_out.read_value    = r2_rd_mem ? dm_rdata : (r2_rd_reg ? r2_regval : 8'd0);
        n_out.reg_written   = r2_rep;
        n_out.written_reg   = r2_rep ? r2_wreg : 4'd0;
        n_out.written_value = r2_rep ? s2_wval : 8'd0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_v2) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // Once halted, every later result reports halted
    a_halt_sticky_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.halted) |=>
            (!o_out_valid || o_out_item.halted))
        else $error("halted dropped after a halted result");

    // The halt flag never clears outside reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    // An execute beat after halt leaves the pc alone
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step1 && kind == KIND_EXEC && r_halt) |=> $stable(r_pc))
        else $error("pc moved after halt");

    // An illegal opcode writes no register
    a_illegal_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.illegal) |-> !o_out_item.reg_written)
        else $error("illegal opcode reported a register write");

endmodule

[src/ebrm_rf.sv]
// Register file: 16 x 8 bits, two banks written alike, three registered read ports.
// Write-first on a read at the write address; valid bits give the all-zero reset.
// Depends on ebrm_pkg.
module ebrm_rf
    import ebrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [REG_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [REG_AW-1:0] i_raddr_a,
    input  logic [REG_AW-1:0] i_raddr_b,
    input  logic [REG_AW-1:0] i_raddr_c,
    output logic [7:0]        o_rdata_a,
    output logic [7:0]        o_rdata_b,
    output logic [7:0]        o_rdata_c
);

    logic [7:0]          r_bank_ab [NUM_REGS];
    logic [7:0]          r_bank_c  [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [7:0]          r_rdata_a;
    logic [7:0]          r_rdata_b;
    logic [7:0]          r_rdata_c;

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Write both banks
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bank_ab[i_waddr] <= i_wdata;
            r_bank_c[i_waddr]  <= i_wdata;
        end
    end

    // Read, passing write data through on an address match
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && i_waddr == i_raddr_a) begin
                r_rdata_a <= i_wdata;
            end else if (r_valid[i_raddr_a]) begin
                r_rdata_a <= r_bank_ab[i_raddr_a];
            end else begin
                r_rdata_a <= '0;
            end
            if (i_we && i_waddr == i_raddr_b) begin
                r_rdata_b <= i_wdata;
            end else if (r_valid[i_raddr_b]) begin
                r_rdata_b <= r_bank_ab[i_raddr_b];
            end else begin
                r_rdata_b <= '0;
            end
            if (i_we && i_waddr == i_raddr_c) begin
                r_rdata_c <= i_wdata;
            end else if (r_valid[i_raddr_c]) begin
                r_rdata_c <= r_bank_c[i_raddr_c];
            end else begin
                r_rdata_c <= '0;
            end
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
    assign o_rdata_c = r_rdata_c;

endmodule

[src/ebrm_dmem.sv]
// Data memory: 256 x 8 bits, one port, registered read data.
// Valid bits per entry give the all-zero reset without a clearing pass.
// Depends on ebrm_pkg.
module ebrm_dmem
    import ebrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [MEM_AW-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0]           r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [7:0]           r_rdata;

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en && i_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    // Write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else if (r_valid[i_addr]) begin
                r_rdata <= r_mem[i_addr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ebrm_exec.sv]
// Execute unit: decodes one instruction and computes its result, address and next pc.
// Purely combinational; operands arrive already forwarded.
// Depends on ebrm_pkg.
module ebrm_exec
    import ebrm_pkg::*;
(
    input  logic [3:0] i_op,
    input  logic [3:0] i_d,
    input  logic [3:0] i_s1,
    input  logic [3:0] i_s2,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    input  logic [7:0] i_dv,
    input  logic [7:0] i_pc,
    output t_exec      o_exec
);

    logic [7:0]  pc_inc;
    logic [15:0] prod;
    logic [7:0]  jmp_target;
    logic [7:0]  beqz_target;

    // Sequential pc, product and branch targets (offset doubled, wraps mod 256)
    assign pc_inc      = i_pc + 8'd2;
    assign prod        = {8'b0, i_a} * {8'b0, i_b};
    assign jmp_target  = pc_inc + {i_d[2:0], i_s1, 1'b0};
    assign beqz_target = pc_inc + {i_s1[2:0], i_s2, 1'b0};

    // Decode
    always_comb begin
        o_exec          = '0;
        o_exec.next_pc  = pc_inc;
        o_exec.addr     = i_a + {{4{i_s2[3]}}, i_s2};
        case (i_op)
            OP_ADD: begin
                o_exec.result = i_a + i_b;
                o_exec.wr     = 1'b1;
            end
            OP_SUB: begin
                o_exec.result = i_a - i_b;
                o_exec.wr     = 1'b1;
            end
            OP_MUL: begin
                o_exec.result = prod[7:0];
                o_exec.wr     = 1'b1;
            end
            OP_INC: begin
                o_exec.result = i_dv + 8'd1;
                o_exec.wr     = 1'b1;
            end
            OP_AND: begin
                o_exec.result = i_a & i_b;
                o_exec.wr     = 1'b1;
            end
            OP_OR: begin
                o_exec.result = i_a | i_b;
                o_exec.wr     = 1'b1;
            end
            OP_NOT: begin
                o_exec.result = ~i_a;
                o_exec.wr     = 1'b1;
            end
            OP_XOR: begin
                o_exec.result = i_a ^ i_b;
                o_exec.wr     = 1'b1;
            end
            OP_LOAD: begin
                o_exec.wr      = 1'b1;
                o_exec.is_load = 1'b1;
            end
            OP_STORE: begin
                o_exec.is_store = 1'b1;
            end
            OP_JMP: begin
                o_exec.next_pc = jmp_target;
            end
            OP_BEQZ: begin
                if (i_dv == 8'd0) begin
                    o_exec.next_pc = beqz_target;
                end
            end
            OP_HLT: begin
                o_exec.halt = 1'b1;
            end
            default: begin
                o_exec.illegal = 1'b1;
            end
        endcase
    end

endmodule
